FILE: hdl/mfbp_pkg.sv
`default_nettype none
package mfbp_pkg;

	// field widths
	localparam int ValueBits = 32;
	localparam int WidthBits = 6;
	localparam int ByteBits  = 8;

	// largest code width accepted; wider requests saturate
	localparam int MaxWidth   = 32;
	localparam int WidthLimit = (MaxWidth < ValueBits) ? MaxWidth : ValueBits;

	// pending byte plus one full code
	localparam int BufBits   = ValueBits + ByteBits;
	localparam int FillBits  = 3;
	localparam int CountBits = 3;
	localparam int MaxBytes  = (ByteBits - 1 + WidthLimit) / ByteBits;

	// request queue between front and back
	localparam int QueueDepth = 2;
	localparam int QPtrBits   = 1;
	localparam int QCntBits   = 2;

	// classified request handed from front to back
	typedef struct packed {
		logic                   flush;
		logic [ValueBits-1:0]   aligned;
		logic [WidthBits-1:0]   width;
	} item_t;

	// queue handshake toward the back
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage
`default_nettype wire

FILE: hdl/mfbp_front.sv
`default_nettype none
module mfbp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [39:0]         s_tdata,  // value[31:0], width[37:32], zero pad
	input  wire logic [0:0]          s_tuser,  // action[0]
	output logic                     push_valid,
	input  wire logic                push_ready,
	output mfbp_pkg::item_t          push_item
);

	logic                              valid_s1;
	mfbp_pkg::item_t                   item_s1;
	mfbp_pkg::item_t                   item_d;
	logic [mfbp_pkg::WidthBits-1:0]    width_in;
	logic [mfbp_pkg::WidthBits-1:0]    width_sat;
	logic [mfbp_pkg::WidthBits-1:0]    lim;
	logic                              keep;

	// saturate width and left-align the code bits
	always_comb begin
		lim       = mfbp_pkg::WidthBits'(mfbp_pkg::WidthLimit);
		width_in  = s_tdata[mfbp_pkg::ValueBits +: mfbp_pkg::WidthBits];
		width_sat = (width_in > lim) ? lim : width_in;
		item_d.flush   = s_tuser[0];
		item_d.width   = width_sat;
		item_d.aligned = s_tdata[mfbp_pkg::ValueBits-1:0]
			<< (mfbp_pkg::WidthBits'(mfbp_pkg::ValueBits) - width_sat);
		// zero-width appends do nothing and are dropped here
		keep = s_tuser[0] || (width_sat != '0);
	end

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// front register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mfbp_queue.sv
`default_nettype none
module mfbp_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire mfbp_pkg::item_t     push_item,
	output mfbp_pkg::qhead_t         head,
	input  wire logic                pop
);

	mfbp_pkg::item_t                  mem_q [mfbp_pkg::QueueDepth];
	logic [mfbp_pkg::QPtrBits-1:0]    wr_ptr_q;
	logic [mfbp_pkg::QPtrBits-1:0]    rd_ptr_q;
	logic [mfbp_pkg::QCntBits-1:0]    count_q;
	logic                             do_push;
	logic                             do_pop;

	assign push_ready = (count_q != mfbp_pkg::QCntBits'(mfbp_pkg::QueueDepth));
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mfbp_back.sv
`default_nettype none
module mfbp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mfbp_pkg::qhead_t    head,
	output logic                     pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,  // out_byte[7:0]
	output logic                     m_tlast
);

	localparam int BB = mfbp_pkg::BufBits;
	localparam int YB = mfbp_pkg::ByteBits;

	logic [BB-1:0]                     buf_q;
	logic [mfbp_pkg::CountBits-1:0]    cnt_q;
	logic [mfbp_pkg::FillBits-1:0]     fill_q;
	logic                              out_valid_q;
	logic [YB-1:0]                     out_byte_q;
	logic                              out_last_q;

	logic                              out_free;
	logic                              idle;
	logic                              emit_shift;
	logic                              emit_flush;
	logic [BB-1:0]                     code_al;
	logic [BB-1:0]                     buf_ld;
	logic [mfbp_pkg::WidthBits-1:0]    total;

	assign out_free = !out_valid_q || m_tready;
	assign idle     = (cnt_q == '0);

	// merge the pending byte with the new code and count the full bytes
	always_comb begin
		code_al = {head.item.aligned, {YB{1'b0}}} >> fill_q;
		buf_ld  = {buf_q[BB-1 -: YB], {(BB-YB){1'b0}}} | code_al;
		total   = mfbp_pkg::WidthBits'(fill_q) + head.item.width;
	end

	// request dispatch
	always_comb begin
		emit_shift = !idle && out_free;
		emit_flush = head.valid && idle && head.item.flush && (fill_q != '0) && out_free;
		pop        = head.valid && idle &&
			(!head.item.flush || (fill_q == '0) || out_free);
	end

	// byte shifter and fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			cnt_q  <= '0;
			fill_q <= '0;
		end else if (emit_shift) begin
			buf_q <= buf_q << YB;
			cnt_q <= cnt_q - 1'b1;
		end else if (pop) begin
			if (head.item.flush) begin
				buf_q  <= '0;
				fill_q <= '0;
			end else begin
				buf_q  <= buf_ld;
				cnt_q  <= total[mfbp_pkg::WidthBits-1:3];
				fill_q <= total[2:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_shift || emit_flush;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_byte_q <= buf_q[BB-1 -: YB];
			out_last_q <= emit_flush || (cnt_q == mfbp_pkg::CountBits'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	// byte count never exceeds what one code can complete
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mfbp_pkg::CountBits'(mfbp_pkg::MaxBytes))
		else $error("byte count out of range");

	// at rest only the pending byte may hold bits
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> (buf_q[BB-YB-1:0] == '0))
		else $error("stale bits below pending byte");

	// unfilled low bits of the pending byte stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> ((buf_q[BB-1 -: YB] & (8'hff >> fill_q)) == '0))
		else $error("pending byte not zero padded");

	// a flush with bits pending leaves the packer empty
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		emit_flush |=> (fill_q == '0) && (buf_q == '0))
		else $error("flush left bits behind");

endmodule
`default_nettype wire

FILE: hdl/msb_first_bit_packer_unit.sv
// msb-first bit packer
// slave channel: one request per s_tvalid/s_tready handshake; s_tuser[0] is
// the action (0 append, 1 flush), s_tdata carries the code value in bits
// 31:0 and its width (0..32, larger values saturate) in bits 37:32
// master channel: one packed byte per m_tvalid/m_tready handshake, earliest
// bit in the msb; m_tlast marks the final byte caused by a request
// path: a request passes a front register and a two-entry queue, then the
// back end loads an append into its shift buffer and sends each completed
// byte through the output register, one per cycle while it is not stalled;
// the next request is taken only when all bytes of the last one are out;
// a flush emits any pending byte, zero-width appends are dropped at the front
// a stalled receiver holds the output register; the back end waits on it
// while the queue and front register keep taking up to three requests
// reset clears the pending byte, its fill count and all valid flags
`default_nettype none
module msb_first_bit_packer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // value[31:0], width[37:32], zero pad
	input  wire logic [0:0]  s_tuser,  // action[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_byte[7:0]
	output logic             m_tlast
);

	logic              push_valid;
	logic              push_ready;
	mfbp_pkg::item_t   push_item;
	mfbp_pkg::qhead_t  head;
	logic              pop;

	// accept and classify requests
	mfbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decoupling queue
	mfbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head       (head),
		.pop        (pop)
	);

	// bit packing and byte output
	mfbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
